/* rtl/deadline_task_scheduler_top_defines.svh */
// ----------------------------------------------------------------------------
// Deadline task scheduler assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TASK_SCHEDULER_TOP_DEFINES_SVH
`define DEADLINE_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define DTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dts_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline task scheduler package
// Beat types, opcode and status codes, and the internal command format.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ONCE     = 2'd1;
  localparam logic [1:0] OP_PERIODIC = 2'd2;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_FIRED    = 2'd1;
  localparam logic [1:0] ST_ACCEPTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPW         = 1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [31:0] start_delay;
    logic [31:0] period;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] fired_task;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ONCE,
    CMD_PERIODIC,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  task_id;
    logic [31:0] deadline;
    logic [31:0] period;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

/* rtl/dts_front.sv */
// ----------------------------------------------------------------------------
// Deadline task scheduler front end
// Takes input beats, decodes the opcode and forms the first deadline.
// ----------------------------------------------------------------------------
module dts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dts_pkg::in_item_t in_data,
  output logic              push,
  output dts_pkg::cmd_t     push_cmd,
  input  logic              q_full
);

  logic          fr_valid_r;
  dts_pkg::cmd_t fr_cmd_r;
  dts_pkg::cmd_t dec_cmd;
  logic          accept;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !q_full;
  assign push_cmd = fr_cmd_r;

  always_comb begin
    dec_cmd.task_id  = in_data.task_id;
    dec_cmd.deadline = in_data.now_ms + in_data.start_delay;
    dec_cmd.now_ms   = in_data.now_ms;
    dec_cmd.period   = 32'd0;
    unique case (in_data.opcode)
      dts_pkg::OP_TICK:     dec_cmd.kind = dts_pkg::CMD_TICK;
      dts_pkg::OP_ONCE:     dec_cmd.kind = dts_pkg::CMD_ONCE;
      dts_pkg::OP_PERIODIC: begin
        dec_cmd.kind   = dts_pkg::CMD_PERIODIC;
        dec_cmd.period = in_data.period;
      end
      default:              dec_cmd.kind = dts_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= dec_cmd;
    end
  end

endmodule

/* rtl/dts_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Deadline task scheduler command queue
// Short FIFO decoupling the decode stage from the slot table sequencer.
// ----------------------------------------------------------------------------
module dts_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dts_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output dts_pkg::cmd_t pop_cmd,
  output logic          nonempty
);

  dts_pkg::cmd_t              entry_r [dts_pkg::QUEUE_DEPTH];
  logic [dts_pkg::QPW-1:0]    wr_ptr_r;
  logic [dts_pkg::QPW-1:0]    rd_ptr_r;
  logic [dts_pkg::QPW:0]      cnt_r;

  assign full     = (cnt_r == (dts_pkg::QPW+1)'(dts_pkg::QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_cmd  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/dts_back.sv */
// ----------------------------------------------------------------------------
// Deadline task scheduler back end
// Slot table, sequential slot scan for insert and tick, and result register.
// ----------------------------------------------------------------------------
module dts_back #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  dts_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_item_t out_data
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_TSCAN,
    S_TDRAIN,
    S_TDECIDE
  } state_t;

  state_t                 state_r;
  logic [TASK_SLOTS-1:0]  valid_r;
  logic [IW-1:0]          idx_r;
  dts_pkg::cmd_t          cmd_r;
  logic                   out_valid_r;
  dts_pkg::out_item_t     out_data_r;

  logic [31:0] dl_mem  [TASK_SLOTS];
  logic [31:0] per_mem [TASK_SLOTS];
  logic        os_mem  [TASK_SLOTS];
  logic [7:0]  id_mem  [TASK_SLOTS];

  logic          rd_ok_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_slot_r;
  logic [31:0]   rd_dl_r;
  logic [31:0]   rd_per_r;
  logic          rd_os_r;
  logic [7:0]    rd_id_r;

  logic          best_found_r;
  logic [IW-1:0] best_slot_r;
  logic [31:0]   best_dl_r;
  logic [31:0]   best_per_r;
  logic          best_os_r;
  logic [7:0]    best_id_r;

  logic          sched_free;
  logic [31:0]   dl_diff;
  logic [31:0]   due_diff;
  logic          take_cand;
  logic          due;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_dl;
  logic [31:0]   wr_per;
  logic          wr_os;
  logic [7:0]    wr_id;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pop       = (state_r == S_IDLE) && q_nonempty && !out_valid_r;

  always_comb begin
    sched_free = !valid_r[idx_r];
    dl_diff    = rd_dl_r - best_dl_r;
    take_cand  = rd_ok_r && rd_vld_r && (!best_found_r || dl_diff[31]);
    due_diff   = cmd_r.now_ms - best_dl_r;
    due        = best_found_r && !due_diff[31];
    wr_en      = 1'b0;
    wr_idx     = idx_r;
    wr_dl      = cmd_r.deadline;
    wr_per     = cmd_r.period;
    wr_os      = (cmd_r.kind == dts_pkg::CMD_ONCE);
    wr_id      = cmd_r.task_id;
    if (state_r == S_SCHED && sched_free) begin
      wr_en = 1'b1;
    end else if (state_r == S_TDECIDE && due && !best_os_r) begin
      wr_en  = 1'b1;
      wr_idx = best_slot_r;
      wr_dl  = cmd_r.now_ms + best_per_r;
      wr_per = best_per_r;
      wr_os  = best_os_r;
      wr_id  = best_id_r;
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_idx]  <= wr_dl;
      per_mem[wr_idx] <= wr_per;
      os_mem[wr_idx]  <= wr_os;
      id_mem[wr_idx]  <= wr_id;
    end
    rd_dl_r   <= dl_mem[idx_r];
    rd_per_r  <= per_mem[idx_r];
    rd_os_r   <= os_mem[idx_r];
    rd_id_r   <= id_mem[idx_r];
    rd_vld_r  <= valid_r[idx_r];
    rd_slot_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (take_cand) begin
      best_slot_r <= rd_slot_r;
      best_dl_r   <= rd_dl_r;
      best_per_r  <= rd_per_r;
      best_os_r   <= rd_os_r;
      best_id_r   <= rd_id_r;
    end
    if (pop) begin
      cmd_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      idx_r        <= '0;
      rd_ok_r      <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      rd_ok_r <= (state_r == S_TSCAN);
      if (take_cand) begin
        best_found_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            idx_r        <= '0;
            best_found_r <= 1'b0;
            unique case (q_cmd.kind)
              dts_pkg::CMD_TICK:     state_r <= S_TSCAN;
              dts_pkg::CMD_ONCE,
              dts_pkg::CMD_PERIODIC: state_r <= S_SCHED;
              dts_pkg::CMD_NOP: begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{status: dts_pkg::ST_NONE, fired_task: 8'd0};
              end
            endcase
          end
        end
        S_SCHED: begin
          if (sched_free) begin
            valid_r[idx_r] <= 1'b1;
            out_valid_r    <= 1'b1;
            out_data_r     <= '{status: dts_pkg::ST_ACCEPTED, fired_task: 8'd0};
            state_r        <= S_IDLE;
          end else if (idx_r == LAST) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: dts_pkg::ST_FULL, fired_task: 8'd0};
            state_r     <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TSCAN: begin
          if (idx_r == LAST) begin
            state_r <= S_TDRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TDRAIN: begin
          state_r <= S_TDECIDE;
        end
        S_TDECIDE: begin
          out_valid_r <= 1'b1;
          if (due) begin
            out_data_r <= '{status: dts_pkg::ST_FIRED, fired_task: best_id_r};
            if (best_os_r) begin
              valid_r[best_slot_r] <= 1'b0;
            end
          end else begin
            out_data_r <= '{status: dts_pkg::ST_NONE, fired_task: 8'd0};
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/deadline_task_scheduler_top.sv */
// A beat passes the front register and the command queue; a tick then scans
// the slot table one slot per cycle (S_TSCAN, S_TDRAIN, S_TDECIDE) and a
// schedule scans for a free slot (S_SCHED) before the result register. A new
// command is popped only when idle and once the last result beat has left.
// Reset (rst_n, synchronous): all slots invalid, queue and result empty.
// ----------------------------------------------------------------------------
// Deadline task scheduler top level
// Decode front end, command queue and slot table sequencer.
// ----------------------------------------------------------------------------
`include "deadline_task_scheduler_top_defines.svh"

module deadline_task_scheduler_top #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_item_t out_data
);

  logic          q_push;
  dts_pkg::cmd_t q_push_cmd;
  logic          q_full;
  logic          q_pop;
  dts_pkg::cmd_t q_pop_cmd;
  logic          q_nonempty;
  logic          q_pop_work;

  assign q_pop_work = q_pop && (q_pop_cmd.kind != dts_pkg::CMD_NOP);

  dts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .q_full   (q_full)
  );

  dts_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .nonempty (q_nonempty)
  );

  dts_back #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_cmd      (q_pop_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `DTS_ASSERT_IMP(a_no_push_full, q_push, !q_full, "push into full command queue")
  `DTS_ASSERT_IMP(a_pop_needs_room, q_pop, q_nonempty && !out_valid, "pop without data or room")
  `DTS_ASSERT_NXT(a_pop_no_early_result, q_pop_work, !out_valid, "result too early")

endmodule

/* bench/deadline_task_scheduler_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline task scheduler testbench
// Directed and random schedule and tick beats are checked against a
// slot-table predictor. Result beats are compared in order. Both sides get
// random gaps and stalls.
// ----------------------------------------------------------------------------
module deadline_task_scheduler_top_test;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned ITEM_TARGET    = 800;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  dts_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dts_pkg::out_item_t out_data;

  deadline_task_scheduler_top #(.TASK_SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // predicted slot table
  logic        tbl_valid    [SLOTS];
  logic [31:0] tbl_deadline [SLOTS];
  logic [31:0] tbl_period   [SLOTS];
  logic        tbl_one_shot [SLOTS];
  logic [7:0]  tbl_id       [SLOTS];

  dts_pkg::in_item_t  pending_items[$];
  dts_pkg::out_item_t awaited_results[$];
  int unsigned beats_in    = 0;
  int unsigned error_count = 0;
  int unsigned quiet_count = 0;
  logic        calm;

  // no idling on either side through this stretch
  assign calm = (beats_in >= 300) && (beats_in < 420);

  function automatic logic deadline_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic dts_pkg::out_item_t advance_task_table(dts_pkg::in_item_t item);
    dts_pkg::out_item_t res;
    int                 best;
    logic [31:0]        lag;
    res.status     = dts_pkg::ST_NONE;
    res.fired_task = 8'd0;
    best           = -1;
    case (item.opcode)
      dts_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] &&
              (best < 0 || deadline_earlier(tbl_deadline[i], tbl_deadline[best])))
            best = i;
        if (best >= 0) begin
          lag = item.now_ms - tbl_deadline[best];
          if (!lag[31]) begin
            res.status     = dts_pkg::ST_FIRED;
            res.fired_task = tbl_id[best];
            if (tbl_one_shot[best])
              tbl_valid[best] = 1'b0;
            else
              tbl_deadline[best] = item.now_ms + tbl_period[best];
          end
        end
      end
      dts_pkg::OP_ONCE, dts_pkg::OP_PERIODIC: begin
        res.status = dts_pkg::ST_FULL;
        for (int i = 0; i < SLOTS; i++)
          if (best < 0 && !tbl_valid[i])
            best = i;
        if (best >= 0) begin
          tbl_valid[best]    = 1'b1;
          tbl_deadline[best] = item.now_ms + item.start_delay;
          tbl_one_shot[best] = (item.opcode == dts_pkg::OP_ONCE);
          tbl_period[best]   = (item.opcode == dts_pkg::OP_ONCE) ? 32'd0 : item.period;
          tbl_id[best]       = item.task_id;
          res.status         = dts_pkg::ST_ACCEPTED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_item(logic [1:0] op, logic [7:0] id, logic [31:0] first,
                            logic [31:0] per, logic [31:0] now);
    dts_pkg::in_item_t item;
    item.opcode      = op;
    item.task_id     = id;
    item.start_delay = first;
    item.period      = per;
    item.now_ms      = now;
    pending_items.push_back(item);
  endtask

  // driver
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(advance_task_table(in_data));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    dts_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat, expected none, actual status %0d task %0d",
                   $time, out_data.status, out_data.fired_task);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.fired_task !== want.fired_task) begin
            error_count++;
            $display("%0t: fired_task mismatch, expected %0d, actual %0d",
                     $time, want.fired_task, out_data.fired_task);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] clock_ms;
    logic [31:0] first;
    logic [31:0] per;
    logic [1:0]  op;
    int unsigned made;
    int unsigned draws;
    int unsigned sched_pct;

    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

    // empty table, unused opcode
    queue_item(dts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0);
    queue_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // equal deadlines: lowest slot first; one-shot ignores period
    queue_item(dts_pkg::OP_ONCE, 8'h00, 32'd0, 32'hFFFF_FFFF, 32'd0);
    queue_item(dts_pkg::OP_PERIODIC, 8'hFF, 32'd0, 32'd50, 32'd0);
    queue_item(dts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0);
    queue_item(dts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0);
    // fill to full, then one insert too many
    for (int k = 1; k < SLOTS; k++)
      queue_item(dts_pkg::OP_ONCE, 8'(k), 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FF80);
    queue_item(dts_pkg::OP_PERIODIC, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(dts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'hFFFF_FF7F);

    // random part, time starts just short of the wrap
    clock_ms  = 32'hFFFF_FF7F;
    made      = 0;
    draws     = 0;
    sched_pct = 50;
    while (made < ITEM_TARGET) begin
      if (draws % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       sched_pct = 25;
          1:       sched_pct = 50;
          default: sched_pct = 75;
        endcase
      end
      if (draws == 500)
        clock_ms = clock_ms + 32'h0800_0000;
      draws++;
      if ($urandom_range(0, 99) < 3) begin
        queue_item(OP_UNUSED, 8'($urandom), $urandom, $urandom, $urandom);
      end else begin
        made++;
        if ($urandom_range(0, 99) < sched_pct) begin
          op = ($urandom_range(0, 99) < 4) ? dts_pkg::OP_PERIODIC : dts_pkg::OP_ONCE;
          case ($urandom_range(0, 29))
            0:       first = $urandom;
            1, 2:    first = 32'd0;
            default: first = $urandom_range(0, 60);
          endcase
          case ($urandom_range(0, 9))
            0:       per = $urandom;
            default: per = $urandom_range(1, 80);
          endcase
          queue_item(op, 8'($urandom), first, per, clock_ms);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 20);
          if ($urandom_range(0, 99) < 4)
            queue_item(dts_pkg::OP_TICK, 8'($urandom), $urandom, $urandom, $urandom);
          else
            queue_item(dts_pkg::OP_TICK, 8'($urandom), $urandom, $urandom, clock_ms);
        end
      end
    end

    while (!rst_n || pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dts_pkg.sv
rtl/dts_front.sv
rtl/dts_cmd_queue.sv
rtl/dts_back.sv
rtl/deadline_task_scheduler_top.sv
bench/deadline_task_scheduler_top_test.sv
